FILE: rtl/core/rnt_pkg.sv
// Shared constants and types for the radix number-to-text core.
`timescale 1ns / 1ps
package rnt_pkg;

  localparam int NUM_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int SYM_VALUES = 256;
  localparam int MAX_DIGITS = 32;
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int DIV_BITS   = 8;
  localparam int DIV_ITER   = NUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_CONVERT = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/rnt_chan_if.sv
// Request and character channel interfaces of the radix number-to-text core.
`timescale 1ns / 1ps
interface rnt_in_if;
  import rnt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [CHAR_W-1:0]       symbol;
  logic signed [NUM_W-1:0] number;

  modport source (output valid, output mode, output symbol, output number, input ready);
  modport sink   (input valid, input mode, input symbol, input number, output ready);
endinterface

interface rnt_out_if;
  import rnt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

FILE: rtl/core/rnt_div.sv
// Iterative restoring divider, DIV_BITS quotient bits per cycle.
`timescale 1ns / 1ps
module rnt_div #(
  parameter int DIV_W = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rnt_pkg::NUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [rnt_pkg::NUM_W-1:0] quotient,
  output logic [DIV_W-1:0]         remainder
);
  import rnt_pkg::*;

  logic [NUM_W-1:0]     q_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;

  logic [NUM_W-1:0]     q_nxt;
  logic [DIV_W-1:0]     rem_nxt;
  logic [DIV_W:0]       part;

  // q shifts dividend bits out the top and quotient bits in the bottom
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    part    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      part  = {rem_nxt, q_nxt[NUM_W-1]};
      q_nxt = {q_nxt[NUM_W-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part     = part - {1'b0, divisor};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = part[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_CNT_W'(1);
        if (step_r == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/radix_number_to_text_core.sv
// Top level: digit alphabet memory, presence map, conversion sequencer.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid / ready  mode[1:0], symbol[7:0], number[31:0] signed
//  out_ch   out  valid / ready  char_out[7:0], last
//
// Clear acts on acceptance; append steps through a position read, an alphabet
// read and a write. A conversion holds in_ch until its last character is in the
// output register: each digit comes from the shared divider (8 quotient bits per
// cycle), then a minus sign if negative, then one alphabet read per character.
// Reset is synchronous; it empties the alphabet, then a pass over all 256 symbol values
// zeroes the symbol position memory while in_ch is not ready.
// in_ch is ready only between requests; the last character may still wait
// in the output register while the next request is taken.
`timescale 1ns / 1ps
module radix_number_to_text_core #(
  parameter int MAX_SYMBOLS = 256
) (
  input logic      clk,
  input logic      rst_n,
  rnt_in_if.sink   in_ch,
  rnt_out_if.source out_ch
);
  import rnt_pkg::*;

  localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int ADDR_W = $clog2(MAX_SYMBOLS);

  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 bad_r, bad_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIG_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]    sym_r, sym_nxt;
  logic [CHAR_W-1:0]    init_r, init_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  // symbol -> its position in the alphabet; the symbol is present when that
  // position is below the length and the alphabet holds the symbol there
  logic [ADDR_W-1:0] pos_mem [SYM_VALUES];
  logic [ADDR_W-1:0] pos_rdata_r;
  logic              pos_rd_en;
  logic              pos_we;
  logic [CHAR_W-1:0] pos_waddr;
  logic [ADDR_W-1:0] pos_wdata;
  logic              dup;

  logic [CHAR_W-1:0] alph_mem [MAX_SYMBOLS];
  logic [CHAR_W-1:0] rdata_r;
  logic              mem_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [ADDR_W-1:0]    dig_r [MAX_DIGITS];
  logic                 push;
  logic [DIG_CNT_W-1:0] cnt_m1;

  logic              accept;
  logic              out_free;
  logic              usable;
  logic              full;
  logic [NUM_W-1:0]  mag;

  logic              div_start;
  logic [NUM_W-1:0]  div_dividend;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [LEN_W-1:0]  div_rem;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign usable   = !bad_r && (len_r >= LEN_W'(2));
  assign full     = len_r >= LEN_W'(MAX_SYMBOLS);
  assign mag      = in_ch.number[NUM_W-1] ? (~in_ch.number + NUM_W'(1)) : in_ch.number;
  assign cnt_m1   = cnt_r - DIG_CNT_W'(1);
  assign rd_addr  = (state_r == ST_LOOK) ? pos_rdata_r : dig_r[cnt_m1[DIG_IDX_W-1:0]];
  assign dup      = (LEN_W'(pos_rdata_r) < len_r) && (rdata_r == sym_r);

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_vld_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;

  rnt_div #(
    .DIV_W(LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    bad_nxt      = bad_r;
    neg_nxt      = neg_r;
    cnt_nxt      = cnt_r;
    sym_nxt      = sym_r;
    init_nxt     = init_r;
    out_vld_nxt  = out_ch.ready ? 1'b0 : out_vld_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    pos_rd_en    = 1'b0;
    pos_we       = 1'b0;
    pos_waddr    = init_r;
    pos_wdata    = '0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    push         = 1'b0;
    div_start    = 1'b0;
    div_dividend = mag;

    unique case (state_r)
      ST_INIT: begin
        pos_we   = 1'b1;
        init_nxt = init_r + CHAR_W'(1);
        if (init_r == CHAR_W'(SYM_VALUES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.mode)
            MODE_CLEAR: begin
              len_nxt = '0;
              bad_nxt = 1'b0;
            end
            MODE_APPEND: begin
              if (in_ch.symbol != '0) begin
                if (full) begin
                  bad_nxt = 1'b1;
                end else begin
                  sym_nxt   = in_ch.symbol;
                  pos_rd_en = 1'b1;
                  state_nxt = ST_LOOK;
                end
              end
            end
            MODE_CONVERT: begin
              if (usable) begin
                neg_nxt   = in_ch.number[NUM_W-1];
                cnt_nxt   = '0;
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        rd_en     = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sym_r == PLUS_CHAR || sym_r == MINUS_CHAR || dup) begin
          bad_nxt = 1'b1;
        end
        mem_we    = 1'b1;
        pos_we    = 1'b1;
        pos_waddr = sym_r;
        pos_wdata = len_r[ADDR_W-1:0];
        len_nxt   = len_r + LEN_W'(1);
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        div_dividend = div_quo;
        if (div_done) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + DIG_CNT_W'(1);
          if (div_quo == '0 || cnt_nxt == DIG_CNT_W'(MAX_DIGITS)) begin
            state_nxt = ST_SIGN;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (!neg_r) begin
          state_nxt = ST_READ;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_char_nxt = MINUS_CHAR;
          out_last_nxt = 1'b0;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        cnt_nxt   = cnt_m1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_char_nxt = rdata_r;
          out_last_nxt = (cnt_r == '0);
          state_nxt    = (cnt_r == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      init_r    <= '0;
      len_r     <= '0;
      bad_r     <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      init_r    <= init_nxt;
      len_r     <= len_nxt;
      bad_r     <= bad_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    sym_r      <= sym_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    // digits come out least significant first; stack them for MSB-first output
    if (push) begin
      dig_r[cnt_r[DIG_IDX_W-1:0]] <= div_rem[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      alph_mem[len_r[ADDR_W-1:0]] <= sym_r;
    end
    if (rd_en) begin
      rdata_r <= alph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_rd_en) begin
      pos_rdata_r <= pos_mem[in_ch.symbol];
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for radix_number_to_text_core: alphabet and conversion checks.
`timescale 1ns / 1ps
module testbench;
  import rnt_pkg::*;

  localparam logic [1:0] MODE_UNUSED     = 2'd3;
  localparam int         ALPHA_DEPTH     = 256;
  localparam int         WATCHDOG_LIMIT  = 5000;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         TAIL_CYCLES     = 300;
  localparam int         RANDOM_REQUESTS = 100;
  localparam int         MAX_PRINTS      = 100;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst_n;

  rnt_in_if  in_ch ();
  rnt_out_if out_ch ();

  radix_number_to_text_core #(.MAX_SYMBOLS(ALPHA_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted alphabet state
  logic [CHAR_W-1:0] alpha_syms [ALPHA_DEPTH];
  logic              alpha_seen [SYM_VALUES];
  int                alpha_len;
  logic              alpha_bad;
  text_char_t        text_q [$];

  int   mismatches    = 0;
  int   requests_sent = 0;
  int   idle_cycles   = 0;
  logic idle_enable   = 1'b1;
  int   tx_calm       = 0;

  // output side pacing
  logic hold_token = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;
  int   stall_left = 0;
  int   calm_left  = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void predict_request(input logic [1:0] mode,
                                          input logic [CHAR_W-1:0] sym,
                                          input logic [NUM_W-1:0] num);
    logic [NUM_W-1:0]  mag;
    logic [CHAR_W-1:0] digits [$];
    text_char_t        rec;
    int                radix;
    radix = alpha_len;
    case (mode)
      MODE_CLEAR: begin
        alpha_len = 0;
        alpha_bad = 1'b0;
        foreach (alpha_seen[i]) alpha_seen[i] = 1'b0;
      end
      MODE_APPEND: begin
        if (sym != '0) begin
          if (alpha_len >= ALPHA_DEPTH) begin
            alpha_bad = 1'b1;
          end else begin
            if (sym == PLUS_CHAR || sym == MINUS_CHAR || alpha_seen[sym]) alpha_bad = 1'b1;
            alpha_seen[sym] = 1'b1;
            alpha_syms[alpha_len] = sym;
            alpha_len++;
          end
        end
      end
      MODE_CONVERT: begin
        if (!alpha_bad && alpha_len >= 2) begin
          // magnitude in 32 unsigned bits keeps -2^31 exact
          mag = num[NUM_W-1] ? ~num + 1'b1 : num;
          do begin
            digits.push_front(alpha_syms[mag % radix]);
            mag = mag / radix;
          end while (mag != 0);
          if (num[NUM_W-1]) begin
            rec.ch = MINUS_CHAR;
            rec.last = 1'b0;
            text_q.push_back(rec);
          end
          foreach (digits[i]) begin
            rec.ch = digits[i];
            rec.last = (i == digits.size() - 1);
            text_q.push_back(rec);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [CHAR_W-1:0] got,
                                 input logic [CHAR_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
  endtask

  task automatic send_request(input logic [1:0] mode, input logic [CHAR_W-1:0] sym,
                              input logic [NUM_W-1:0] num);
    if (tx_calm > 0) begin
      tx_calm--;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end else if ($urandom_range(0, 15) == 0) begin
      tx_calm = $urandom_range(10, 40);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.symbol <= sym;
    in_ch.number <= num;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_request(mode, sym, num);
    if (mode != MODE_UNUSED && !(mode == MODE_APPEND && sym == '0)) requests_sent++;
  endtask

  task automatic clear_req();
    send_request(MODE_CLEAR, 8'($urandom_range(0, 255)), $urandom);
  endtask

  task automatic append_req(input logic [CHAR_W-1:0] sym);
    send_request(MODE_APPEND, sym, $urandom);
  endtask

  task automatic convert_req(input logic [NUM_W-1:0] num);
    send_request(MODE_CONVERT, 8'($urandom_range(0, 255)), num);
  endtask

  // withdraw the last request, then wait for every predicted character
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (text_q.size() != 0);
  endtask

  // clear, then append count distinct usable symbols
  task automatic load_alphabet(input int count);
    logic              taken [SYM_VALUES];
    logic [CHAR_W-1:0] sym;
    foreach (taken[i]) taken[i] = 1'b0;
    clear_req();
    repeat (count) begin
      do sym = 8'($urandom_range(1, 255));
      while (taken[sym] || sym == PLUS_CHAR || sym == MINUS_CHAR);
      taken[sym] = 1'b1;
      append_req(sym);
    end
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'd1;
          2: return '1;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      1: return $urandom_range(0, 300);
      2: return 32'd0 - $urandom_range(1, 300);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_unusable_alphabets();
    convert_req(32'd12345);                 // nothing loaded since reset
    send_request(MODE_UNUSED, 8'h31, 32'd1);
    append_req(8'h00);                      // zero byte is ignored
    append_req(8'h61);
    convert_req(32'd7);                     // single symbol
    append_req(8'h61);
    append_req(8'h62);
    convert_req(32'd7);                     // repeated symbol
    clear_req();
    append_req(8'h30);
    append_req(8'h31);
    append_req(MINUS_CHAR);
    convert_req(-32'sd5);
    clear_req();
    append_req(PLUS_CHAR);
    append_req(8'h30);
    convert_req(32'd5);
    wait_drained();
  endtask

  task automatic test_binary_extremes();
    clear_req();
    append_req(8'hFF);
    append_req(8'h80);
    convert_req('0);
    convert_req(32'd1);
    convert_req('1);
    convert_req(32'h7FFF_FFFF);
    convert_req(32'h8000_0000);
    convert_req(32'h5555_5555);
  endtask

  task automatic test_wide_alphabet();
    logic [CHAR_W-1:0] order [$];
    logic [CHAR_W-1:0] tmp;
    int                j;
    for (int s = 1; s < SYM_VALUES; s++)
      if (s != PLUS_CHAR && s != MINUS_CHAR) order.push_back(s[CHAR_W-1:0]);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    clear_req();
    foreach (order[i]) append_req(order[i]);
    convert_req(32'h8000_0000);
    convert_req(32'h7FFF_FFFF);
    convert_req(32'd252);
    convert_req(32'd253);
    convert_req(pick_number());
    // sign symbols and a repeat fill the store, then one more is dropped
    append_req(PLUS_CHAR);
    append_req(MINUS_CHAR);
    append_req(order[0]);
    append_req(order[1]);
    convert_req(pick_number());
    wait_drained();
  endtask

  task automatic test_backpressure();
    clear_req();
    append_req(8'h30);
    append_req(8'h31);
    hold_token <= ~hold_token;
    repeat (4) convert_req(32'h8000_0000);
    wait_drained();
    convert_req(pick_number());
    wait_drained();
  endtask

  task automatic test_random_sequences();
    int start;
    int kind;
    start = requests_sent;
    while (requests_sent - start < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        load_alphabet(($urandom_range(0, 5) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(2, 16));
        repeat ($urandom_range(1, 6)) convert_req(pick_number());
      end else if (kind < 9) begin
        // short alphabet, or a bad symbol slipped into a good one
        load_alphabet($urandom_range(0, 6));
        case ($urandom_range(0, 3))
          0: append_req(PLUS_CHAR);
          1: append_req(MINUS_CHAR);
          2: if (alpha_len > 0) append_req(alpha_syms[$urandom_range(0, alpha_len - 1)]);
          default: ;
        endcase
        repeat ($urandom_range(1, 3)) convert_req(pick_number());
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
      end
    end
  endtask

  task automatic test_full_rate();
    idle_enable <= 1'b0;
    repeat (4) begin
      load_alphabet($urandom_range(2, 16));
      repeat (4) convert_req(pick_number());
    end
  endtask

  // output side: pacing, checking
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (text_q.size() == 0) begin
        report_mismatch("unexpected char_out", out_ch.char_out, '0);
      end else begin
        want = text_q.pop_front();
        if (out_ch.char_out !== want.ch) report_mismatch("char_out", out_ch.char_out, want.ch);
        if (out_ch.last !== want.last)
          report_mismatch("last", CHAR_W'(out_ch.last), CHAR_W'(want.last));
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left    <= calm_left - 1;
      out_ch.ready <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0) calm_left <= $urandom_range(20, 60);
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_CLEAR;
    in_ch.symbol = '0;
    in_ch.number = '0;
    out_ch.ready = 1'b0;
    alpha_len    = 0;
    alpha_bad    = 1'b0;
    foreach (alpha_syms[i]) alpha_syms[i] = '0;
    foreach (alpha_seen[i]) alpha_seen[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_unusable_alphabets();
    test_binary_extremes();
    test_wide_alphabet();
    test_backpressure();
    test_random_sequences();
    test_full_rate();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rnt_pkg.sv
rtl/core/rnt_chan_if.sv
rtl/core/rnt_div.sv
rtl/core/radix_number_to_text_core.sv
bench/testbench.sv
